// ===== design/assert_macros.svh =====
// Assertion macros shared by the quorum vote recorder RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== design/qvr_pkg.sv =====
// Package for the quorum vote recorder: field widths, codes, state type.
// Depends on nothing; used by quorum_vote_recorder.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    localparam int MAX_VOTERS_DEF = 16;

    localparam int EPOCH_W   = 62;
    localparam int CUR_EP_W  = 63;
    localparam int ADDR_W    = 48;
    localparam int REPL_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int VCOUNT_W  = 5;

    localparam int S_DATA_W  = 160;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 120;

    localparam logic [REPL_W-1:0] REPLICA_RESET = 5'd3;

    localparam logic OP_RECORD  = 1'b0;
    localparam logic OP_CORRECT = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_STALE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== design/quorum_vote_recorder.sv =====
// Quorum vote recorder top level: epoch/leader tracking and voter table scan.
// Depends on qvr_pkg, qvr_ram and assert_macros.svh.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: epoch, sender, proposed_leader
//                                             tuser: operation, carries_leader
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, vote_count, majority,
//                                             current_epoch, agreed_leader, leader_known
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_data: replica_count
//
// One word at a time: accept, an evaluate state, a scan that compares one stored voter
// per cycle (up to MAX_VOTERS-1), and a finish state that hands the result to the output
// register.
// Reset (synchronous, active low) clears epoch to -1, count, leader, output valid.
// A word is taken while a result still waits on m_axis; the finish cycle stalls
// until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module quorum_vote_recorder #(
    parameter int MAX_VOTERS = qvr_pkg::MAX_VOTERS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tdata: epoch[61:0], sender[109:62], proposed_leader[157:110], zero fill
    input  wire logic [qvr_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[0], carries_leader[1]
    input  wire logic [qvr_pkg::S_USER_W-1:0]  s_axis_tuser,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: status[1:0], vote_count[6:2], majority_reached[7],
    //        current_epoch[70:8], agreed_leader[118:71], leader_known[119]
    output logic      [qvr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [qvr_pkg::REPL_W-1:0]    i_cfg_data
);

    import qvr_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
    localparam int CW = $clog2(MAX_VOTERS + 1);

    // Registers
    t_state                     r_state, n_state;
    logic [REPL_W-1:0]          r_repl;
    logic signed [CUR_EP_W-1:0] r_epoch, n_epoch;
    logic [CW-1:0]              r_count, n_count;
    logic [ADDR_W-1:0]          r_leader, n_leader;
    logic                       r_lvalid, n_lvalid;
    logic [AW-1:0]              r_idx, n_idx;
    logic [STATUS_W-1:0]        r_status, n_status;
    // Held copy of the accepted word
    logic                       r_op;
    logic [EPOCH_W-1:0]         r_ep;
    logic [ADDR_W-1:0]          r_sender;
    logic                       r_has_ldr;
    logic [ADDR_W-1:0]          r_prop;
    // Output register
    logic                       r_m_valid;
    logic [M_DATA_W-1:0]        r_m_data;

    // RAM side
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [AW-1:0]              w_raddr;
    logic [ADDR_W-1:0]          w_rdata;

    logic                       w_s_acc;
    logic                       w_out_free;
    logic signed [CUR_EP_W-1:0] w_ep_s;
    logic                       w_newer;
    logic                       w_older;
    logic                       w_last;
    logic [CW+4:0]              w_cnt_ext;
    logic [CW+4:0]              w_thresh;
    logic                       w_major;
    logic                       w_dup_empty;

    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // Incoming epoch is unsigned; extend with a zero sign bit
    assign w_ep_s  = $signed({1'b0, r_ep});
    assign w_newer = w_ep_s > r_epoch;
    assign w_older = w_ep_s < r_epoch;

    // Last stored voter reached in the scan
    assign w_last = (CW'(r_idx) + CW'(1)) == r_count;

    // Majority: count >= replica_count/2 + 1
    assign w_cnt_ext = {5'd0, r_count};
    assign w_thresh  = (CW+5)'(r_repl[REPL_W-1:1]) + (CW+5)'(1);
    assign w_major   = w_cnt_ext >= w_thresh;

    // Read entry 0 on evaluate, then walk upward one entry a cycle
    assign w_raddr = (r_state == ST_SCAN) ? (r_idx + AW'(1)) : '0;

    qvr_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_VOTERS),
        .AW    (AW)
    ) u_voters (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sender),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        logic [CW-1:0]     v_cnt;
        logic [ADDR_W-1:0] v_ldr;
        logic              v_lv;

        n_state  = r_state;
        n_epoch  = r_epoch;
        n_count  = r_count;
        n_leader = r_leader;
        n_lvalid = r_lvalid;
        n_idx    = r_idx;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_count[AW-1:0];
        v_cnt    = r_count;
        v_ldr    = r_leader;
        v_lv     = r_lvalid;

        case (r_state)
            ST_IDLE: begin
                n_idx    = '0;
                n_status = STAT_OK;
                if (w_s_acc) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_DONE;
                if (r_op == OP_CORRECT) begin
                    // Lower a too-new epoch and drop the round
                    if (w_older == 1'b0 && w_newer == 1'b0) begin
                        n_epoch = r_epoch;
                    end else if (w_older) begin
                        n_epoch  = w_ep_s;
                        n_count  = '0;
                        n_leader = '0;
                        n_lvalid = 1'b0;
                    end
                end else if (w_older) begin
                    n_status = STAT_STALE;
                end else begin
                    if (w_newer) begin
                        n_epoch = w_ep_s;
                        v_cnt   = '0;
                        v_ldr   = '0;
                        v_lv    = 1'b0;
                    end
                    if (r_has_ldr) begin
                        if (!v_lv) begin
                            v_ldr = r_prop;
                            v_lv  = 1'b1;
                        end else if (r_prop != v_ldr) begin
                            v_cnt = '0;
                            v_ldr = r_prop;
                            v_lv  = 1'b1;
                        end
                    end
                    n_leader = v_ldr;
                    n_lvalid = v_lv;
                    n_count  = v_cnt;
                    if (v_cnt >= CW'(MAX_VOTERS)) begin
                        // Table full: ignore the sender
                        n_count = v_cnt;
                    end else if (v_cnt == '0) begin
                        // Empty table: store the sender as first voter
                        w_we    = 1'b1;
                        w_waddr = '0;
                        n_count = CW'(1);
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_rdata == r_sender) begin
                    n_status = STAT_DUP;
                    n_state  = ST_DONE;
                end else if (w_last) begin
                    // No match: append at the end of the table
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_repl    <= REPLICA_RESET;
            r_epoch   <= '1;
            r_count   <= '0;
            r_leader  <= '0;
            r_lvalid  <= 1'b0;
            r_idx     <= '0;
            r_status  <= STAT_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_epoch  <= n_epoch;
            r_count  <= n_count;
            r_leader <= n_leader;
            r_lvalid <= n_lvalid;
            r_idx    <= n_idx;
            r_status <= n_status;
            if (i_cfg_valid && o_cfg_ready) begin
                r_repl <= i_cfg_data;
            end
            // Hold the result until taken; load a new one on finish
            if (r_state == ST_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the accepted word and the finished result
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_op      <= s_axis_tuser[0];
            r_has_ldr <= s_axis_tuser[1];
            r_ep      <= s_axis_tdata[61:0];
            r_sender  <= s_axis_tdata[109:62];
            r_prop    <= s_axis_tdata[157:110];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_m_data <= {r_lvalid, r_leader, r_epoch, w_major,
                         w_cnt_ext[VCOUNT_W-1:0], r_status};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Checks
    assign w_dup_empty = (r_status == STAT_DUP) && (r_count == '0);

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_VOTERS), "count above depth")
    `ASSERT_CLK(a_accept_eval, i_clk, i_rst_n, w_s_acc |=> (r_state == ST_EVAL), "missed evaluate")
    `ASSERT_CLK(a_write_room, i_clk, i_rst_n, w_we |-> (CW'(w_waddr) < n_count), "write past count")
    `ASSERT_NEVER(a_dup_empty, i_clk, i_rst_n, w_dup_empty, "duplicate reported on empty table")

endmodule

`default_nettype wire

// ===== design/qvr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module qvr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== verif/quorum_vote_recorder_checker.sv =====
// Checker for the quorum vote recorder: follows the input, output and config channels,
// predicts each result word and compares it field by field. Depends on qvr_pkg.
`timescale 1ns / 1ps

module quorum_vote_recorder_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tdata: epoch, sender, proposed_leader, zero fill
    input  wire logic [qvr_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation, carries_leader
    input  wire logic [qvr_pkg::S_USER_W-1:0]  s_axis_tuser,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    // tdata: status, vote_count, majority_reached, current_epoch, agreed_leader,
    //        leader_known
    input  wire logic [qvr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [qvr_pkg::REPL_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import qvr_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VCOUNT_W-1:0] vote_count;
        logic                majority;
        logic [CUR_EP_W-1:0] epoch;
        logic [ADDR_W-1:0]   leader;
        logic                leader_known;
    } tally_t;

    tally_t            expected_tallies[$];
    logic [REPL_W-1:0] replicas;
    longint            round_epoch;
    int                voter_total;
    logic [ADDR_W-1:0] voters[MAX_VOTERS_DEF];
    logic [ADDR_W-1:0] leader_addr;
    bit                leader_ok;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_round();
        voter_total = 0;
        leader_addr = '0;
        leader_ok   = 1'b0;
    endfunction

    // Advance the round state by one input word and return what the block should report.
    function automatic tally_t tally_vote(input logic op, input logic [EPOCH_W-1:0] ep,
                                          input logic [ADDR_W-1:0] sender, input logic carries,
                                          input logic [ADDR_W-1:0] proposal);
        tally_t t;
        longint epv;
        bit     done;
        epv      = longint'({2'b00, ep});
        t.status = STAT_OK;
        done     = 1'b0;
        if (op == OP_CORRECT) begin
            if (round_epoch > epv) begin
                clear_round();
                round_epoch = epv;
            end
        end else begin
            if (epv > round_epoch) begin
                clear_round();
                round_epoch = epv;
            end else if (epv < round_epoch) begin
                t.status = STAT_STALE;
                done     = 1'b1;
            end
            if (!done && carries) begin
                // a differing proposal restarts the voter list under the new leader
                if (leader_ok && proposal != leader_addr)
                    clear_round();
                leader_addr = proposal;
                leader_ok   = 1'b1;
            end
            // full table: drop the sender without a scan
            if (!done && voter_total >= MAX_VOTERS_DEF)
                done = 1'b1;
            for (int i = 0; i < voter_total && !done; i++) begin
                if (voters[i] == sender) begin
                    t.status = STAT_DUP;
                    done     = 1'b1;
                end
            end
            if (!done) begin
                voters[voter_total] = sender;
                voter_total++;
            end
        end
        t.vote_count   = voter_total[VCOUNT_W-1:0];
        t.majority     = voter_total >= int'(replicas) / 2 + 1;
        t.epoch        = round_epoch[CUR_EP_W-1:0];
        t.leader       = leader_ok ? leader_addr : '0;
        t.leader_known = leader_ok;
        return t;
    endfunction

    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        o_fail_count++;
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        tally_t want;
        tally_t got;
        if (!i_rst_n) begin
            replicas    = REPLICA_RESET;
            round_epoch = -1;
            clear_round();
            expected_tallies.delete();
        end else begin
            // retire the result first; it always belongs to an older word
            if (m_axis_tvalid && m_axis_tready) begin
                got.status       = m_axis_tdata[1:0];
                got.vote_count   = m_axis_tdata[6:2];
                got.majority     = m_axis_tdata[7];
                got.epoch        = m_axis_tdata[70:8];
                got.leader       = m_axis_tdata[118:71];
                got.leader_known = m_axis_tdata[119];
                if (expected_tallies.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: unexpected result word %0h", $time, m_axis_tdata);
                end else begin
                    want = expected_tallies.pop_front();
                    if (got.status !== want.status)
                        flag("status", 64'(want.status), 64'(got.status));
                    if (got.vote_count !== want.vote_count)
                        flag("vote_count", 64'(want.vote_count), 64'(got.vote_count));
                    if (got.majority !== want.majority)
                        flag("majority_reached", 64'(want.majority), 64'(got.majority));
                    if (got.epoch !== want.epoch)
                        flag("current_epoch", 64'(want.epoch), 64'(got.epoch));
                    if (got.leader !== want.leader)
                        flag("agreed_leader", 64'(want.leader), 64'(got.leader));
                    if (got.leader_known !== want.leader_known)
                        flag("leader_known", 64'(want.leader_known), 64'(got.leader_known));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_tallies.push_back(tally_vote(s_axis_tuser[0], s_axis_tdata[61:0],
                                                      s_axis_tdata[109:62], s_axis_tuser[1],
                                                      s_axis_tdata[157:110]));
            if (i_cfg_valid && i_cfg_ready)
                replicas = i_cfg_data;
        end
        o_pending = expected_tallies.size();
    end

endmodule

// ===== verif/quorum_vote_recorder_test.sv =====
// Testbench top for quorum_vote_recorder: clock, reset, vote stimulus and verdict.
// Depends on qvr_pkg, quorum_vote_recorder and quorum_vote_recorder_checker.
`timescale 1ns / 1ps

module quorum_vote_recorder_test;
    import qvr_pkg::*;

    localparam logic [EPOCH_W-1:0] EPOCH_TOP = {EPOCH_W{1'b1}};
    localparam int                 POOL_N    = 20;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [S_USER_W-1:0]   s_axis_tuser  = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire logic             s_axis_tready;
    wire logic [M_DATA_W-1:0] m_axis_tdata;
    wire logic             m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    wire logic             o_cfg_ready;
    logic [REPL_W-1:0]     i_cfg_data    = '0;

    int fail_count;
    int pending;

    // idle odds in percent for each side
    int send_idle = 0;
    int recv_idle = 0;

    // newest epoch the block should hold; steers stimulus toward live rounds
    longint            live_epoch = -1;
    logic [ADDR_W-1:0] sender_pool[POOL_N];
    logic [ADDR_W-1:0] leader_pool[3];

    quorum_vote_recorder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    quorum_vote_recorder_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel at random; recv_idle = 0 keeps it always ready.
    always @(negedge i_clk) begin
        m_axis_tready = $urandom_range(0, 99) >= recv_idle;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [EPOCH_W-1:0] rand_epoch();
        return EPOCH_W'({$urandom, $urandom});
    endfunction

    // Move one word over the input channel, with random idle cycles ahead of it.
    // Runs from a falling edge and returns on the falling edge after the handshake.
    task automatic send_word(input logic op, input logic [EPOCH_W-1:0] ep,
                             input logic [ADDR_W-1:0] who, input logic carries,
                             input logic [ADDR_W-1:0] prop);
        longint epv;
        epv = longint'({2'b00, ep});
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {{(S_DATA_W - EPOCH_W - 2 * ADDR_W){1'b0}}, prop, who, ep};
        s_axis_tuser  = {carries, op};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        // follow the epoch so later words stay in the live round
        if (op == OP_RECORD && epv > live_epoch)
            live_epoch = epv;
        if (op == OP_CORRECT && live_epoch > epv)
            live_epoch = epv;
    endtask

    // Drain every pending result, then hold a little longer before touching config.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (MAX_VOTERS_DEF + 4) @(negedge i_clk);
    endtask

    task automatic write_replicas(input logic [REPL_W-1:0] value);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Edge cases, run with a replica count of zero so a single vote is a majority.
    task automatic run_directed();
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        a = rand_addr();
        b = rand_addr();
        // correction with nothing recorded: no change
        send_word(OP_CORRECT, '0, rand_addr(), 1'b1, rand_addr());
        send_word(OP_RECORD, '0, '0, 1'b0, '0);
        // same sender again: duplicate
        send_word(OP_RECORD, '0, '0, 1'b0, rand_addr());
        send_word(OP_RECORD, '0, {ADDR_W{1'b1}}, 1'b1, {ADDR_W{1'b1}});
        // differing leader: clear voters, adopt, record sender first
        send_word(OP_RECORD, '0, a, 1'b1, '0);
        // newer epoch, then first leader on a repeat sender: adopted and duplicate
        send_word(OP_RECORD, 62'd5, a, 1'b0, rand_addr());
        send_word(OP_RECORD, 62'd5, a, 1'b1, b);
        send_word(OP_RECORD, 62'd3, rand_addr(), 1'b1, rand_addr());
        // fill the table, then one more sender lands on a full table
        for (int i = 1; i < MAX_VOTERS_DEF; i++)
            send_word(OP_RECORD, 62'd5, a ^ ADDR_W'(i), 1'b1, b);
        send_word(OP_RECORD, 62'd5, ~a, 1'b1, b);
        send_word(OP_RECORD, EPOCH_TOP, rand_addr(), 1'b0, rand_addr());
        // correction at the current epoch leaves the round alone, downward clears it
        send_word(OP_CORRECT, EPOCH_TOP, rand_addr(), 1'b0, rand_addr());
        send_word(OP_CORRECT, 62'd2, rand_addr(), 1'b1, rand_addr());
    endtask

    // Random rounds: open mostly with a newer epoch, then mostly votes in that round with
    // repeat senders and the odd leader change, mixed with stale, corrections and noise.
    task automatic run_rounds(input int quota);
        int                sent;
        int                votes;
        int                pick;
        int                back;
        logic [EPOCH_W-1:0] ep;
        logic [ADDR_W-1:0]  who;
        logic [ADDR_W-1:0]  prop;
        sent = 0;
        while (sent < quota) begin
            for (int j = 0; j < POOL_N; j++)
                sender_pool[j] = rand_addr();
            for (int j = 0; j < 3; j++)
                leader_pool[j] = rand_addr();
            if ($urandom_range(0, 9) == 0 || live_epoch < 0)
                ep = rand_epoch();
            else if (live_epoch > longint'(EPOCH_TOP) - 4)
                ep = live_epoch[EPOCH_W-1:0];
            else
                ep = EPOCH_W'(live_epoch + $urandom_range(1, 3));
            send_word(OP_RECORD, ep, sender_pool[0], 1'b1, leader_pool[0]);
            sent++;
            votes = $urandom_range(1, 22);
            for (int k = 1; k <= votes && sent < quota; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 82) begin
                    who  = $urandom_range(0, 6) == 0 ? sender_pool[$urandom_range(0, POOL_N - 1)]
                                                    : sender_pool[k % POOL_N];
                    prop = $urandom_range(0, 11) == 0 ? leader_pool[$urandom_range(1, 2)]
                                                     : leader_pool[0];
                    send_word(OP_RECORD, live_epoch[EPOCH_W-1:0], who,
                              $urandom_range(0, 3) != 0, prop);
                end else if (pick < 89) begin
                    back = $urandom_range(1, 5);
                    ep   = live_epoch >= back ? EPOCH_W'(live_epoch - back) : '0;
                    send_word(OP_RECORD, ep, rand_addr(), 1'($urandom_range(0, 1)),
                              rand_addr());
                end else if (pick < 95) begin
                    back = $urandom_range(0, 3);
                    if (back == 3)
                        ep = EPOCH_W'(live_epoch + 1);
                    else
                        ep = live_epoch >= back ? EPOCH_W'(live_epoch - back) : '0;
                    send_word(OP_CORRECT, ep, rand_addr(), 1'($urandom_range(0, 1)),
                              rand_addr());
                end else begin
                    ep = $urandom_range(0, 1) ? rand_epoch() : live_epoch[EPOCH_W-1:0];
                    send_word(1'($urandom_range(0, 1)), ep, rand_addr(),
                              1'($urandom_range(0, 1)), rand_addr());
                end
                sent++;
            end
        end
    endtask

    initial begin
        logic [REPL_W-1:0] replica_plan[6];
        replica_plan = '{5'd31, 5'd1, 5'd3, 5'd16, 5'd7, 5'd2};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_idle = 34;
        recv_idle = 70;
        write_replicas(5'd0);
        run_directed();

        // three idle patterns, two replica settings each
        for (int p = 0; p < 3; p++) begin
            send_idle = p == 0 ? 34 : (p == 1 ? 70 : 0);
            recv_idle = p == 0 ? 70 : (p == 1 ? 34 : 0);
            for (int c = 0; c < 2; c++) begin
                settle();
                write_replicas(replica_plan[2 * p + c]);
                run_rounds(215);
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
